### design/seven_segment_frame_decoder_defines.svh
// Assertion helpers for the top-level design file.
`ifndef SEVEN_SEGMENT_FRAME_DECODER_DEFINES_SVH
`define SEVEN_SEGMENT_FRAME_DECODER_DEFINES_SVH

// Condition a must bring condition b in the same cycle.
`define SSFD_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Condition a must bring condition b in the next cycle.
`define SSFD_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

### design/ssfd_pkg.sv
package ssfd_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'h5A;
    localparam logic [7:0] MARKER_BYTE = 8'h01;
    localparam int unsigned DOT_BIT    = 7;

    localparam logic [3:0]  DIGIT_BAD    = 4'd10;
    localparam logic [13:0] HEIGHT_MAX   = 14'd9990;

    typedef struct packed {
        logic [7:0] hund;
        logic [7:0] tens;
        logic [7:0] units;
        logic [7:0] check;
    } t_frame;

    // Map a segment pattern (dot masked off) to its digit, DIGIT_BAD if unknown.
    function automatic logic [3:0] seg_to_digit(input logic [7:0] seg_byte);
        logic [3:0] d;
        unique case (seg_byte[6:0])
            7'b0111111: d = 4'd0;
            7'b0000110: d = 4'd1;
            7'b1011011: d = 4'd2;
            7'b1001111: d = 4'd3;
            7'b1100110: d = 4'd4;
            7'b1101101: d = 4'd5;
            7'b1111101: d = 4'd6;
            7'b0000111: d = 4'd7;
            7'b1111111: d = 4'd8;
            7'b1101111: d = 4'd9;
            default:    d = DIGIT_BAD;
        endcase
        return d;
    endfunction

endpackage

### design/ssfd_frame.sv
module ssfd_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_frm_valid,
    input  logic              i_frm_ready,
    output ssfd_pkg::t_frame  o_frame
);

    typedef enum logic [2:0] {
        POS_HUNT,
        POS_DIGIT1,
        POS_DIGIT2,
        POS_DIGIT3,
        POS_MARKER,
        POS_CHECK
    } t_pos;

    t_pos             r_pos;
    logic [7:0]       r_hund;
    logic [7:0]       r_tens;
    logic [7:0]       r_units;
    logic             r_frm_valid;
    ssfd_pkg::t_frame r_frame;
    logic             w_accept;

    assign o_ready     = !r_frm_valid || i_frm_ready;
    assign w_accept    = i_valid && o_ready;
    assign o_frm_valid = r_frm_valid;
    assign o_frame     = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HUNT;
            r_frm_valid <= 1'b0;
        end else begin
            if (w_accept && (r_pos == POS_CHECK)) begin
                r_frm_valid <= 1'b1;
            end else if (i_frm_ready) begin
                r_frm_valid <= 1'b0;
            end
            if (w_accept) begin
                unique case (r_pos)
                    POS_DIGIT1: begin
                        r_hund <= i_rx_byte;
                        r_pos  <= POS_DIGIT2;
                    end
                    POS_DIGIT2: begin
                        r_tens <= i_rx_byte;
                        r_pos  <= POS_DIGIT3;
                    end
                    POS_DIGIT3: begin
                        r_units <= i_rx_byte;
                        r_pos   <= POS_MARKER;
                    end
                    POS_MARKER: begin
                        // drop back to hunting on a bad marker, byte not rechecked as sync
                        r_pos <= (i_rx_byte == ssfd_pkg::MARKER_BYTE) ? POS_CHECK : POS_HUNT;
                    end
                    POS_CHECK: begin
                        r_frame.hund  <= r_hund;
                        r_frame.tens  <= r_tens;
                        r_frame.units <= r_units;
                        r_frame.check <= i_rx_byte;
                        r_pos         <= POS_HUNT;
                    end
                    default: begin
                        r_pos <= (i_rx_byte == ssfd_pkg::SYNC_BYTE) ? POS_DIGIT1 : POS_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

### design/ssfd_value.sv
module ssfd_value (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frm_valid,
    output logic              o_frm_ready,
    input  ssfd_pkg::t_frame  i_frame,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [13:0]       o_height_tenths,
    output logic              o_digit_invalid,
    output logic [7:0]        o_checksum_raw
);

    logic        r_valid;
    logic [13:0] r_height;
    logic        r_invalid;
    logic [7:0]  r_check;

    logic [3:0]  w_h;
    logic [3:0]  w_t;
    logic [3:0]  w_u;
    logic        w_bad;
    logic [9:0]  w_sum;
    logic [13:0] w_sum_wide;
    logic [13:0] n_height;

    assign o_frm_ready = !r_valid || i_ready;

    always_comb begin
        w_h   = ssfd_pkg::seg_to_digit(i_frame.hund);
        w_t   = ssfd_pkg::seg_to_digit(i_frame.tens);
        w_u   = ssfd_pkg::seg_to_digit(i_frame.units);
        w_bad = (w_h == ssfd_pkg::DIGIT_BAD) || (w_t == ssfd_pkg::DIGIT_BAD)
             || (w_u == ssfd_pkg::DIGIT_BAD);
        // h*100 + t*10 + u with shifts: 100 = 64+32+4, 10 = 8+2
        w_sum = ({w_h, 6'b0} + {1'b0, w_h, 5'b0} + {4'b0, w_h, 2'b0})
              + ({3'b0, w_t, 3'b0} + {5'b0, w_t, 1'b0}) + {6'b0, w_u};
        w_sum_wide = {4'b0, w_sum};
        if (w_bad) begin
            n_height = '0;
        end else if (i_frame.tens[ssfd_pkg::DOT_BIT]) begin
            n_height = w_sum_wide;
        end else begin
            n_height = {w_sum_wide[10:0], 3'b0} + {w_sum_wide[12:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_frm_ready) begin
            r_valid <= i_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frm_ready && i_frm_valid) begin
            r_height  <= n_height;
            r_invalid <= w_bad;
            r_check   <= i_frame.check;
        end
    end

    assign o_valid         = r_valid;
    assign o_height_tenths = r_height;
    assign o_digit_invalid = r_invalid;
    assign o_checksum_raw  = r_check;

endmodule

### design/seven_segment_frame_decoder.sv
// Frame decoder for a six-byte display link: 0x5A sync, three seven-segment
// digit bytes (hundreds, tens, units), 0x01 marker, checksum. One byte is
// taken per cycle while o_rx_ready is high; a result goes through a frame
// register and then the result register once the checksum byte is transferred.
// While a result waits, the result register holds it and one more finished
// frame may wait in the frame register; only when both are full does
// o_rx_ready drop, and it follows i_res_ready in the same cycle. Bytes flow at
// one per cycle as long as results are taken. A bad sync or marker byte returns
// the tracker to hunting. The value is in tenths: the tens dot marks a value
// already in tenths, otherwise it is scaled by ten. An unknown segment
// pattern sets o_digit_invalid and forces o_height_tenths to 0. The
// checksum is passed through without checking.
`include "seven_segment_frame_decoder_defines.svh"

module seven_segment_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [13:0] o_height_tenths,
    output logic        o_digit_invalid,
    output logic [7:0]  o_checksum_raw
);

    logic             w_frm_valid;
    logic             w_frm_ready;
    ssfd_pkg::t_frame w_frame;

    ssfd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_rx_valid),
        .o_ready     (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_frm_valid (w_frm_valid),
        .i_frm_ready (w_frm_ready),
        .o_frame     (w_frame)
    );

    ssfd_value u_value (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frm_valid     (w_frm_valid),
        .o_frm_ready     (w_frm_ready),
        .i_frame         (w_frame),
        .o_valid         (o_res_valid),
        .i_ready         (i_res_ready),
        .o_height_tenths (o_height_tenths),
        .o_digit_invalid (o_digit_invalid),
        .o_checksum_raw  (o_checksum_raw)
    );

    `SSFD_ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, o_res_valid && o_digit_invalid, o_height_tenths == 14'd0, "invalid result with nonzero height")
    `SSFD_ASSERT_SAME(a_height_range, i_clk, i_rst_n, o_res_valid, o_height_tenths <= ssfd_pkg::HEIGHT_MAX, "height out of range")
    `SSFD_ASSERT_NEXT(a_frame_held, i_clk, i_rst_n, w_frm_valid && !w_frm_ready, w_frm_valid, "stalled frame lost")
    `SSFD_ASSERT_SAME(a_result_source, i_clk, i_rst_n, $rose(o_res_valid), $past(w_frm_valid), "result without a frame")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned RANDOM_FRAMES = 161;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned TAIL_CYCLES   = 8;

    // Segment patterns of the digits 0..9, dot bit excluded.
    localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef enum logic [2:0] {
        AWAIT_SYNC,
        AWAIT_HUND,
        AWAIT_TENS,
        AWAIT_UNITS,
        AWAIT_MARKER,
        AWAIT_CHECK
    } t_frame_pos;

    typedef struct packed {
        logic [13:0] height;
        logic        invalid;
        logic [7:0]  check;
    } t_reading;

    class t_frame_scoreboard;
        t_frame_pos  pos;
        logic [7:0]  digits [3];
        t_reading    readings_q [$];
        int unsigned errors;

        function new();
            pos    = AWAIT_SYNC;
            errors = 0;
            foreach (digits[i]) digits[i] = '0;
        endfunction

        // Digit value of a segment byte, 10 when the pattern is unknown.
        function int unsigned segment_value(logic [7:0] seg_byte);
            for (int unsigned d = 0; d < 10; d++) begin
                if (DIGIT_SEGMENTS[d] == seg_byte[6:0]) return d;
            end
            return 10;
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned h, t, u, value;
            t_reading    r;
            case (pos)
                AWAIT_HUND: begin
                    digits[0] = b;
                    pos = AWAIT_TENS;
                end
                AWAIT_TENS: begin
                    digits[1] = b;
                    pos = AWAIT_UNITS;
                end
                AWAIT_UNITS: begin
                    digits[2] = b;
                    pos = AWAIT_MARKER;
                end
                AWAIT_MARKER: begin
                    pos = (b == ssfd_pkg::MARKER_BYTE) ? AWAIT_CHECK : AWAIT_SYNC;
                end
                AWAIT_CHECK: begin
                    h = segment_value(digits[0]);
                    t = segment_value(digits[1]);
                    u = segment_value(digits[2]);
                    r.invalid = (h > 9 || t > 9 || u > 9);
                    value = 0;
                    if (!r.invalid) begin
                        value = h * 100 + t * 10 + u;
                        // No dot on the tens digit: scale to tenths.
                        if (!digits[1][ssfd_pkg::DOT_BIT]) value = value * 10;
                    end
                    r.height = value[13:0];
                    r.check  = b;
                    readings_q.push_back(r);
                    pos = AWAIT_SYNC;
                end
                default: begin
                    pos = (b == ssfd_pkg::SYNC_BYTE) ? AWAIT_HUND : AWAIT_SYNC;
                end
            endcase
        endfunction

        function void check_reading(logic [13:0] height, logic invalid, logic [7:0] check);
            t_reading exp_r;
            if (readings_q.size() == 0) begin
                $error("unexpected result: height_tenths=%0d digit_invalid=%0d checksum_raw=%0h",
                       height, invalid, check);
                errors++;
                return;
            end
            exp_r = readings_q.pop_front();
            if (height !== exp_r.height) begin
                $error("height_tenths: expected %0d, actual %0d", exp_r.height, height);
                errors++;
            end
            if (invalid !== exp_r.invalid) begin
                $error("digit_invalid: expected %0d, actual %0d", exp_r.invalid, invalid);
                errors++;
            end
            if (check !== exp_r.check) begin
                $error("checksum_raw: expected %0h, actual %0h", exp_r.check, check);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return readings_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_ready;
    logic [13:0] o_height_tenths;
    logic        o_digit_invalid;
    logic [7:0]  o_checksum_raw;

    t_frame_scoreboard sb;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       hold_req;
    int unsigned       hold_done;

    seven_segment_frame_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_height_tenths (o_height_tenths),
        .o_digit_invalid (o_digit_invalid),
        .o_checksum_raw  (o_checksum_raw)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offer one byte and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.note_byte(b);
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_digit_byte();
        logic [7:0] b;
        if ($urandom_range(99) < 85) begin
            b[6:0] = DIGIT_SEGMENTS[$urandom_range(9)];
            b[7]   = 1'($urandom_range(1));
        end else begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    task automatic send_random_frame();
        if ($urandom_range(99) < 8) send_byte(8'($urandom_range(255)));
        send_byte(($urandom_range(99) < 96) ? ssfd_pkg::SYNC_BYTE : 8'($urandom_range(255)));
        repeat (3) send_byte(random_digit_byte());
        send_byte(($urandom_range(99) < 92) ? ssfd_pkg::MARKER_BYTE : 8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
    endtask

    task automatic set_idling(input int unsigned phase);
        case (phase)
            0: begin
                send_idle_pct = 36;
                recv_idle_pct = 58;
            end
            1: begin
                send_idle_pct = 58;
                recv_idle_pct = 36;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                i_res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done++;
            end else begin
                i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            sb.check_reading(o_height_tenths, o_digit_invalid, o_checksum_raw);
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [7:0]  directed [25];
        int unsigned phase;

        sb = new();
        i_rst_n     = 1'b0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        i_res_ready = 1'b0;
        hold_req    = 0;
        hold_done   = 0;
        set_idling(0);

        // Not a sync byte; 999 scaled (max); dots everywhere (zero);
        // blank tens (invalid); bad marker that holds the sync value;
        // a digit byte dropped while hunting.
        directed = '{
            8'hFF,
            ssfd_pkg::SYNC_BYTE, 8'h6F, 8'h6F, 8'h6F, ssfd_pkg::MARKER_BYTE, 8'h00,
            ssfd_pkg::SYNC_BYTE, 8'hBF, 8'hBF, 8'hBF, ssfd_pkg::MARKER_BYTE, 8'hFF,
            ssfd_pkg::SYNC_BYTE, 8'h06, 8'h80, 8'h5B, ssfd_pkg::MARKER_BYTE, 8'h7E,
            ssfd_pkg::SYNC_BYTE, 8'h4F, 8'h66, 8'h6D, ssfd_pkg::SYNC_BYTE,
            8'h7D
        };

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_byte(directed[i]);

        phase = 0;
        for (int unsigned f = 0; f < RANDOM_FRAMES; f++) begin
            if (f * 3 / RANDOM_FRAMES != phase) begin
                phase = f * 3 / RANDOM_FRAMES;
                @(negedge i_clk);
                i_rx_valid <= 1'b0;
                wait_for_results();
                set_idling(phase);
            end
            if (f == 20) begin
                // Stall results while bytes keep coming at full rate.
                hold_req++;
                send_idle_pct = 0;
                repeat (8) send_random_frame();
                set_idling(phase);
            end
            send_random_frame();
        end

        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/ssfd_pkg.sv
design/ssfd_frame.sv
design/ssfd_value.sv
design/seven_segment_frame_decoder.sv
test/testbench.sv
